>>> rtl/arrival_speed_profile_limiter_core_macros.svh
// Assertion macros for the arrival speed profile limiter.
`ifndef ARRIVAL_SPEED_PROFILE_LIMITER_CORE_MACROS_SVH
`define ARRIVAL_SPEED_PROFILE_LIMITER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// check cons in the same cycle as ante
`define ASPL_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define ASPL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASPL_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg)
`define ASPL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

>>> rtl/aspl_pkg.sv
// Types, constants and codes shared by the arrival speed profile limiter.
`default_nettype none

package aspl_pkg;

  localparam int RATE_HZ   = 10;
  localparam int ACC_FAST  = 650;
  localparam int DEC_FAST  = 450;
  localparam int ACC_SLOW  = 350;
  localparam int DEC_SLOW  = 350;

  localparam logic [12:0] ARRIVAL_THRESHOLD = 13'd10;

  localparam logic [15:0] EXTRA_BIAS_FAST = 16'((ACC_FAST + DEC_FAST) / (2 * RATE_HZ));
  localparam logic [15:0] EXTRA_BIAS_SLOW = 16'((ACC_SLOW + DEC_SLOW) / (2 * RATE_HZ));
  localparam logic [14:0] DEC_STEP_FAST   = 15'(DEC_FAST / RATE_HZ);
  localparam logic [14:0] DEC_STEP_SLOW   = 15'(DEC_SLOW / RATE_HZ);
  localparam logic [14:0] ACC_STEP_FAST   = 15'(ACC_FAST / RATE_HZ);
  localparam logic [14:0] ACC_STEP_SLOW   = 15'(ACC_SLOW / RATE_HZ);

  localparam int          DIV10_SHIFT = 19;
  localparam logic [15:0] DIV10_RECIP =
    16'(((64'd1 << DIV10_SHIFT) + 64'(RATE_HZ) - 64'd1) / 64'(RATE_HZ));

  localparam int          DSTOP_SHIFT = 36;
  localparam logic [26:0] DSTOP_RECIP_FAST =
    27'(((64'd1 << DSTOP_SHIFT) + 64'(2 * DEC_FAST) - 64'd1) / 64'(2 * DEC_FAST));
  localparam logic [26:0] DSTOP_RECIP_SLOW =
    27'(((64'd1 << DSTOP_SHIFT) + 64'(2 * DEC_SLOW) - 64'd1) / 64'(2 * DEC_SLOW));

  typedef enum logic [0:0] {
    CFG_MAX_LINEAR_SPEED = 1'b0,
    CFG_ARRIVAL_SPEED    = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ACT_DECEL  = 2'd0,
    ACT_BRAKE  = 2'd1,
    ACT_ACCEL  = 2'd2,
    ACT_CRUISE = 2'd3
  } action_t;

  typedef struct packed {
    logic signed [13:0] measured_speed;
    logic [16:0]        goal_distance;
    logic [15:0]        reach_offset;
  } in_t;

  typedef struct packed {
    logic signed [13:0] speed_order;
    action_t            action;
  } out_t;

  typedef struct packed {
    logic               fast;
    logic signed [13:0] v;
    logic signed [17:0] rem;
    logic [12:0]        d;
    logic [14:0]        xa;
    logic               xneg;
    logic [13:0]        va;
    logic               vneg;
  } prep_t;

  typedef struct packed {
    logic               fast;
    logic signed [13:0] v;
    logic signed [17:0] rem;
    logic [16:0]        dstop;
    logic signed [12:0] extra;
    logic signed [11:0] v10;
  } mult_t;

endpackage

`default_nettype wire

>>> rtl/aspl_prep.sv
// Operand stage: speed excess, remaining distance and magnitudes for division.
`default_nettype none

module aspl_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  aspl_pkg::in_t  in_data,
  input  logic [12:0]    arrival_speed,
  output logic           out_valid,
  input  logic           out_ready,
  output aspl_pkg::prep_t out_data
);

  logic            valid;
  aspl_pkg::prep_t data;
  aspl_pkg::prep_t data_next;

  logic signed [14:0] diff;
  logic signed [15:0] x;
  logic signed [15:0] xabs;
  logic signed [14:0] vext;
  logic signed [14:0] vabs;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next.fast = arrival_speed > aspl_pkg::ARRIVAL_THRESHOLD;
    data_next.v    = in_data.measured_speed;
    diff = {in_data.measured_speed[13], in_data.measured_speed} - {2'b00, arrival_speed};
    if (diff > 15'sd0) begin
      data_next.d = diff[12:0];
    end else begin
      data_next.d = 13'd0;
    end
    data_next.rem = {1'b0, in_data.goal_distance} - {2'b00, in_data.reach_offset};
    x = {in_data.measured_speed[13], in_data.measured_speed, 1'b0}
      + (data_next.fast ? aspl_pkg::EXTRA_BIAS_FAST : aspl_pkg::EXTRA_BIAS_SLOW);
    data_next.xneg = x[15];
    xabs = x[15] ? -x : x;
    data_next.xa = xabs[14:0];
    vext = {in_data.measured_speed[13], in_data.measured_speed};
    data_next.vneg = vext[14];
    vabs = vext[14] ? -vext : vext;
    data_next.va = vabs[13:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/aspl_mult.sv
// Multiply stages: square of the speed excess and reciprocal divisions.
`default_nettype none

module aspl_mult (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  aspl_pkg::prep_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output aspl_pkg::mult_t out_data
);

  typedef struct packed {
    logic               fast;
    logic signed [13:0] v;
    logic signed [17:0] rem;
    logic [25:0]        sq;
    logic [11:0]        xq;
    logic               xneg;
    logic [10:0]        vq;
    logic               vneg;
  } square_t;

  logic            sq_valid;
  logic            sq_ready;
  square_t         sq_data;
  square_t         sq_next;
  logic [30:0]     xprod;
  logic [29:0]     vprod;

  logic            md_valid;
  aspl_pkg::mult_t md_data;
  aspl_pkg::mult_t md_next;
  logic [26:0]     recip;
  logic [52:0]     dprod;
  logic signed [12:0] xq_s;
  logic signed [11:0] vq_s;

  assign in_ready  = !sq_valid || sq_ready;
  assign sq_ready  = !md_valid || out_ready;
  assign out_valid = md_valid;
  assign out_data  = md_data;

  always_comb begin
    sq_next.fast = in_data.fast;
    sq_next.v    = in_data.v;
    sq_next.rem  = in_data.rem;
    sq_next.sq   = 26'(in_data.d) * 26'(in_data.d);
    xprod        = 31'(in_data.xa) * 31'(aspl_pkg::DIV10_RECIP);
    vprod        = 30'(in_data.va) * 30'(aspl_pkg::DIV10_RECIP);
    sq_next.xq   = xprod[aspl_pkg::DIV10_SHIFT +: 12];
    sq_next.xneg = in_data.xneg;
    sq_next.vq   = vprod[aspl_pkg::DIV10_SHIFT +: 11];
    sq_next.vneg = in_data.vneg;
  end

  always_comb begin
    recip = sq_data.fast ? aspl_pkg::DSTOP_RECIP_FAST : aspl_pkg::DSTOP_RECIP_SLOW;
    dprod = 53'(sq_data.sq) * 53'(recip);
    xq_s  = {1'b0, sq_data.xq};
    vq_s  = {1'b0, sq_data.vq};
    md_next.fast  = sq_data.fast;
    md_next.v     = sq_data.v;
    md_next.rem   = sq_data.rem;
    md_next.dstop = dprod[aspl_pkg::DSTOP_SHIFT +: 17];
    md_next.extra = sq_data.xneg ? -xq_s : xq_s;
    md_next.v10   = sq_data.vneg ? -vq_s : vq_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      md_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        sq_valid <= in_valid;
      end
      if (sq_ready) begin
        md_valid <= sq_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sq_data <= sq_next;
    end
    if (sq_ready && sq_valid) begin
      md_data <= md_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/aspl_decide.sv
// Decision and clamp stages: pick the action, step the speed, limit the order.
`default_nettype none

module aspl_decide (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  aspl_pkg::mult_t in_data,
  input  logic [12:0]     max_linear_speed,
  output logic            out_valid,
  input  logic            out_ready,
  output aspl_pkg::out_t  out_data
);

  logic               dc_valid;
  logic               dc_ready;
  logic signed [14:0] dc_order;
  logic signed [14:0] order_next;
  aspl_pkg::action_t  dc_action;
  aspl_pkg::action_t  action_next;

  logic signed [18:0] rem_x;
  logic signed [18:0] dstop_x;
  logic signed [18:0] v10_x;
  logic signed [18:0] reach_x;
  logic signed [14:0] v_x;

  logic               cl_valid;
  aspl_pkg::out_t     cl_data;
  aspl_pkg::out_t     cl_next;
  logic signed [14:0] vmax_x;
  logic signed [14:0] clamped;

  assign in_ready  = !dc_valid || dc_ready;
  assign dc_ready  = !cl_valid || out_ready;
  assign out_valid = cl_valid;
  assign out_data  = cl_data;

  always_comb begin
    rem_x   = {in_data.rem[17], in_data.rem};
    dstop_x = {2'b00, in_data.dstop};
    v10_x   = {{7{in_data.v10[11]}}, in_data.v10};
    reach_x = dstop_x + {{6{in_data.extra[12]}}, in_data.extra};
    v_x     = {in_data.v[13], in_data.v};
    if (rem_x < dstop_x) begin
      action_next = aspl_pkg::ACT_DECEL;
      order_next  = v_x - (in_data.fast ? aspl_pkg::DEC_STEP_FAST : aspl_pkg::DEC_STEP_SLOW);
    end else if (rem_x < v10_x) begin
      action_next = aspl_pkg::ACT_BRAKE;
      order_next  = 15'sd0;
    end else if (rem_x > reach_x) begin
      action_next = aspl_pkg::ACT_ACCEL;
      order_next  = v_x + (in_data.fast ? aspl_pkg::ACC_STEP_FAST : aspl_pkg::ACC_STEP_SLOW);
    end else begin
      action_next = aspl_pkg::ACT_CRUISE;
      order_next  = v_x;
    end
  end

  always_comb begin
    vmax_x = {2'b00, max_linear_speed};
    if (dc_order < -vmax_x) begin
      clamped = -vmax_x;
    end else if (dc_order > vmax_x) begin
      clamped = vmax_x;
    end else begin
      clamped = dc_order;
    end
    cl_next.speed_order = clamped[13:0];
    cl_next.action      = dc_action;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_valid <= 1'b0;
      cl_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        dc_valid <= in_valid;
      end
      if (dc_ready) begin
        cl_valid <= dc_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dc_order  <= order_next;
      dc_action <= action_next;
    end
    if (dc_ready && dc_valid) begin
      cl_data <= cl_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/arrival_speed_profile_limiter_core.sv
// Top level of the arrival speed profile limiter: config registers and pipeline.
//
// Usage:
//   Each request on in_data carries measured speed, goal distance and reach
//   offset; each one gives exactly one result on out_data: the clamped speed
//   order and the action code (decelerate, emergency brake, accelerate, cruise).
//   Both channels are valid/ready. cfg_we writes max_linear_speed (index 0)
//   or arrival_speed (index 1) from cfg_wdata; write only while no request
//   is in flight.
//   A request accepted on in_data shows on out_valid after passing through
//   five register stages: operand stage, square and divide-by-ten multiplies,
//   stopping-distance reciprocal multiply, decision, and clamp into the output
//   register. Throughput is one request per cycle while out_ready stays high.
//   Every stage holds its own valid bit and fills empty slots while the
//   output stalls; in_ready drops only when all five stages are full and
//   out_ready is low. Nothing is lost or repeated across a stall.
//   Reset empties the pipeline and clears both registers to 0.
`default_nettype none

`include "arrival_speed_profile_limiter_core_macros.svh"

module arrival_speed_profile_limiter_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  aspl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output aspl_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_addr,
  input  logic [12:0]    cfg_wdata
);

  logic [12:0] max_linear_speed;
  logic [12:0] arrival_speed;

  logic            prep_valid;
  logic            prep_ready;
  aspl_pkg::prep_t prep_data;
  logic            mult_valid;
  logic            mult_ready;
  aspl_pkg::mult_t mult_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_linear_speed <= 13'd0;
      arrival_speed    <= 13'd0;
    end else if (cfg_we) begin
      case (aspl_pkg::cfg_index_t'(cfg_addr))
        aspl_pkg::CFG_MAX_LINEAR_SPEED: max_linear_speed <= cfg_wdata;
        aspl_pkg::CFG_ARRIVAL_SPEED:    arrival_speed    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  aspl_prep u_prep (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .arrival_speed (arrival_speed),
    .out_valid     (prep_valid),
    .out_ready     (prep_ready),
    .out_data      (prep_data)
  );

  aspl_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (mult_valid),
    .out_ready (mult_ready),
    .out_data  (mult_data)
  );

  aspl_decide u_decide (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (mult_valid),
    .in_ready         (mult_ready),
    .in_data          (mult_data),
    .max_linear_speed (max_linear_speed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

  `ASPL_ASSERT_NOW(a_brake_zero, clk, rst, out_valid && out_data.action == aspl_pkg::ACT_BRAKE, out_data.speed_order == 14'sd0, "brake result with nonzero order")
  `ASPL_ASSERT_NOW(a_clamp, clk, rst, out_valid, ($signed(out_data.speed_order) <= $signed({1'b0, max_linear_speed})) && ($signed(out_data.speed_order) >= -$signed({1'b0, max_linear_speed})), "order outside speed limit")
  `ASPL_ASSERT_NOW(a_stall_only, clk, rst, !in_ready, out_valid && !out_ready, "input held off without output stall")

endmodule

`default_nettype wire

>>> bench/tb_arrival_speed_profile_limiter_core.sv
// Testbench for the arrival speed profile limiter: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module tb_arrival_speed_profile_limiter_core;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  localparam int GAP_PCT_ONE_SIDE = 46;
  localparam int GAP_PCT_BOTH     = 6;
  localparam int PHASE_REQUESTS   = 205;
  localparam int SETTLE_CYCLES    = 8;
  localparam int CYCLE_LIMIT      = 200000;

  class speed_order_board;
    aspl_pkg::out_t pending_orders[$];
    int unsigned mismatches;
    int speed_limit;
    int arrival_target;

    function int decel_rate();
      return (arrival_target > int'(aspl_pkg::ARRIVAL_THRESHOLD)) ?
        aspl_pkg::DEC_FAST : aspl_pkg::DEC_SLOW;
    endfunction

    function int accel_rate();
      return (arrival_target > int'(aspl_pkg::ARRIVAL_THRESHOLD)) ?
        aspl_pkg::ACC_FAST : aspl_pkg::ACC_SLOW;
    endfunction

    function int stop_distance(int v);
      int d;
      if (v <= arrival_target) return 0;
      d = v - arrival_target;
      return (d * d) / (2 * decel_rate());
    endfunction

    function int cruise_margin(int v);
      return (2 * v + (accel_rate() + decel_rate()) / (2 * aspl_pkg::RATE_HZ)) /
        aspl_pkg::RATE_HZ;
    endfunction

    function aspl_pkg::out_t predict_order(aspl_pkg::in_t req);
      int v;
      int rem;
      int stop;
      int order;
      aspl_pkg::out_t res;
      v = int'($signed(req.measured_speed));
      rem = int'(req.goal_distance) - int'(req.reach_offset);
      stop = stop_distance(v);
      if (rem < stop) begin
        res.action = aspl_pkg::ACT_DECEL;
        order = v - decel_rate() / aspl_pkg::RATE_HZ;
      end else if (rem < v / aspl_pkg::RATE_HZ) begin
        res.action = aspl_pkg::ACT_BRAKE;
        order = 0;
      end else if (rem > stop + cruise_margin(v)) begin
        res.action = aspl_pkg::ACT_ACCEL;
        order = v + accel_rate() / aspl_pkg::RATE_HZ;
      end else begin
        res.action = aspl_pkg::ACT_CRUISE;
        order = v;
      end
      if (order < -speed_limit) order = -speed_limit;
      if (order > speed_limit) order = speed_limit;
      res.speed_order = 14'(order);
      return res;
    endfunction

    function void note_request(aspl_pkg::in_t req);
      pending_orders.insert(pending_orders.size(), predict_order(req));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(aspl_pkg::out_t got);
      aspl_pkg::out_t want;
      if (pending_orders.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      want = pending_orders.pop_front();
      if (got.speed_order !== want.speed_order)
        report_mismatch($sformatf("speed_order got %0d want %0d",
                                  got.speed_order, want.speed_order));
      if (got.action !== want.action)
        report_mismatch($sformatf("action got %0d want %0d", got.action, want.action));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  aspl_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  aspl_pkg::out_t out_data;
  logic cfg_we;
  logic [0:0] cfg_addr;
  logic [12:0] cfg_wdata;

  speed_order_board board;
  flow_mode_t flow_mode = FLOW_FREE;
  int unsigned cycles = 0;

  arrival_speed_profile_limiter_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    case (flow_mode)
      FLOW_RECEIVER_STALLS: out_ready = ($urandom_range(0, 99) >= GAP_PCT_ONE_SIDE);
      FLOW_BOTH: out_ready = ($urandom_range(0, 99) >= GAP_PCT_BOTH);
      default: out_ready = 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  function automatic int sender_gap_pct();
    case (flow_mode)
      FLOW_SENDER_GAPS: return GAP_PCT_ONE_SIDE;
      FLOW_BOTH: return GAP_PCT_BOTH;
      default: return 0;
    endcase
  endfunction

  task automatic send_request(aspl_pkg::in_t req);
    while ($urandom_range(0, 99) < sender_gap_pct()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (!in_ready);
    board.note_request(req);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (board.pending_orders.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(aspl_pkg::cfg_index_t idx, logic [12:0] value);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == aspl_pkg::CFG_MAX_LINEAR_SPEED) board.speed_limit = int'(value);
    else board.arrival_target = int'(value);
  endtask

  task automatic set_limits(int speed_cap, int arrival);
    drain();
    write_register(aspl_pkg::CFG_MAX_LINEAR_SPEED, 13'(speed_cap));
    write_register(aspl_pkg::CFG_ARRIVAL_SPEED, 13'(arrival));
  endtask

  // aim the remaining distance at one of the decision boundaries, or leave it to chance
  function automatic aspl_pkg::in_t make_request();
    aspl_pkg::in_t req;
    int v;
    int rem;
    int reach;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      req.measured_speed = 14'($urandom);
      req.goal_distance = 17'($urandom);
      req.reach_offset = 16'($urandom);
      return req;
    end
    if (roll < 40) v = int'($urandom_range(0, 1200)) - 600;
    else v = int'($urandom_range(0, 16000)) - 8000;
    case ($urandom_range(0, 3))
      0: rem = board.stop_distance(v);
      1: rem = v / aspl_pkg::RATE_HZ;
      2: rem = board.stop_distance(v) + board.cruise_margin(v);
      default: rem = int'($urandom_range(0, 196606)) - 65535;
    endcase
    rem = rem + int'($urandom_range(0, 8)) - 4;
    if (rem < -65535) rem = -65535;
    if (rem > 131071) rem = 131071;
    if (rem >= 0) reach = $urandom_range(0, (131071 - rem < 65535) ? 131071 - rem : 65535);
    else reach = $urandom_range(-rem, 65535);
    req.measured_speed = 14'(v);
    req.goal_distance = 17'(rem + reach);
    req.reach_offset = 16'(reach);
    return req;
  endfunction

  initial begin
    aspl_pkg::in_t directed[$];
    int limit_tab[6];
    int arrival_tab[6];
    int speed_cap;
    int arrival;

    limit_tab = '{8191, 0, 3000, 3000, 8191, 1200};
    arrival_tab = '{0, 8191, 10, 11, 8191, 250};
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = aspl_pkg::CFG_MAX_LINEAR_SPEED;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset limits: every order clamps to zero
    send_request('{14'sd0, 17'd131071, 16'd0});
    send_request('{14'sd8000, 17'd0, 16'd0});
    send_request('{14'h2000, 17'd0, 16'd65535});
    send_request('{14'sd400, 17'd10, 16'd0});

    set_limits(8000, 500);
    directed = '{
      '{14'sd0, 17'd131071, 16'd0},
      '{14'sd8000, 17'd1000, 16'd0},
      '{14'sd400, 17'd10, 16'd0},
      '{14'sd400, 17'd85, 16'd0},
      '{14'sd400, 17'd86, 16'd0},
      '{14'sd400, 17'd40, 16'd0},
      '{14'sd400, 17'd39, 16'd0},
      '{14'sd0, 17'd0, 16'd65535},
      '{14'h2000, 17'd131071, 16'd65535},
      '{14'sd8191, 17'd131071, 16'd0},
      '{14'sd8191, 17'd0, 16'd0},
      '{-14'sd8000, 17'd0, 16'd0},
      '{-14'sd8000, 17'd100, 16'd200},
      '{-14'sd15, 17'd0, 16'd0},
      '{14'sd7950, 17'd65000, 16'd0},
      '{14'sd600, 17'd65635, 16'd65535}
    };
    foreach (directed[i]) send_request(directed[i]);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 6) begin
        speed_cap = limit_tab[phase];
        arrival = arrival_tab[phase];
      end else begin
        speed_cap = $urandom_range(0, 8191);
        arrival = $urandom_range(0, 8191);
      end
      set_limits(speed_cap, arrival);
      flow_mode = flow_mode_t'(phase % 4);
      repeat (PHASE_REQUESTS) send_request(make_request());
    end

    drain();
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> arrival_speed_profile_limiter_core.f
+incdir+rtl
rtl/aspl_pkg.sv
rtl/aspl_prep.sv
rtl/aspl_mult.sv
rtl/aspl_decide.sv
rtl/arrival_speed_profile_limiter_core.sv
bench/tb_arrival_speed_profile_limiter_core.sv
